[rtl/assert_macros.svh]
// Assertion macros used by the top level to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, switched off while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

[rtl/mbps_pkg.sv]
// Package with widths, register indexes and types of the masked byte pattern search.
package mbps_pkg;

  localparam int unsigned DATA_W          = 8;
  localparam int unsigned OUT_OFF_W       = 32;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned PAT_WORDS       = 4;
  localparam int unsigned MASK_W          = 32;
  localparam int unsigned LEN_CFG_W       = 6;
  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LO     = 3'd0,
    REG_PAT_MID_LO = 3'd1,
    REG_PAT_MID_HI = 3'd2,
    REG_PAT_HI     = 3'd3,
    REG_CARE_MASK  = 3'd4,
    REG_PAT_LEN    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [PAT_WORDS*CFG_DATA_W-1:0] pattern;
    logic [MASK_W-1:0]               care_mask;
    logic [LEN_CFG_W-1:0]            length;
  } cfg_t;

endpackage

[rtl/mbps_in_if.sv]
// Input channel carrying one region byte per word.
interface mbps_in_if;
  import mbps_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              region_end;

  modport source (output valid, output data_byte, output region_end, input ready);
  modport sink (input valid, input data_byte, input region_end, output ready);
endinterface

[rtl/mbps_out_if.sv]
// Result channel carrying one search result per word.
interface mbps_out_if;
  import mbps_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [OUT_OFF_W-1:0] match_offset;
  logic                 region_done;

  modport source (output valid, output found, output match_offset, output region_done,
                  input ready);
  modport sink (input valid, input found, input match_offset, input region_done,
                output ready);
endinterface

[rtl/mbps_cfg_if.sv]
// Configuration write channel carrying a register index and write data.
interface mbps_cfg_if;
  import mbps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mbps_match.sv]
// Masked window compare of the recent bytes against the aligned pattern.
module mbps_match #(
  parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  localparam int unsigned EFF_MAX = (MAX_PATTERN < 32) ? MAX_PATTERN : 32,
  localparam int unsigned LEN_W   = $clog2(EFF_MAX + 1)
) (
  input  mbps_pkg::cfg_t                      cfg_i,
  input  logic [EFF_MAX*mbps_pkg::DATA_W-1:0] hist_i,
  output logic                                hit_o,
  output logic [LEN_W-1:0]                    len_o
);
  import mbps_pkg::*;

  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          shift;
  logic [EFF_MAX*DATA_W-1:0] rev_pat;
  logic [EFF_MAX-1:0]        rev_mask;
  logic [EFF_MAX*DATA_W-1:0] al_pat;
  logic [EFF_MAX-1:0]        al_mask;
  logic [EFF_MAX-1:0]        ok;

  // Clamp the configured length to the supported pattern size.
  always_comb begin
    if (cfg_i.length > LEN_CFG_W'(EFF_MAX)) begin
      len = LEN_W'(EFF_MAX);
    end else begin
      len = LEN_W'(cfg_i.length);
    end
    shift = LEN_W'(EFF_MAX) - len;
  end

  // Reverse the pattern so that age j of the history lines up with pattern byte len-1-j.
  always_comb begin
    for (int k = 0; k < EFF_MAX; k++) begin
      rev_pat[k*DATA_W +: DATA_W] = cfg_i.pattern[(EFF_MAX-1-k)*DATA_W +: DATA_W];
      rev_mask[k]                 = cfg_i.care_mask[EFF_MAX-1-k];
    end
    al_pat  = rev_pat >> {shift, 3'b000};
    al_mask = rev_mask >> shift;
  end

  always_comb begin
    for (int j = 0; j < EFF_MAX; j++) begin
      ok[j] = (LEN_W'(j) >= len) || !al_mask[j] ||
              (hist_i[j*DATA_W +: DATA_W] == al_pat[j*DATA_W +: DATA_W]);
    end
  end

  assign hit_o = (&ok) && (len != '0);
  assign len_o = len;

endmodule

[rtl/masked_byte_pattern_search_top.sv]
// Top level of the masked byte pattern search.
// The block scans a region one byte per input word and reports the first place
// where the configured pattern matches; cleared care-mask bits mark wildcards.
// Channel in_i takes words of data_byte and region_end, where region_end marks the
// last byte of a region. Channel out_o gives at most one word per input word:
// found with the match start offset, or a not-found word when the region ends
// without a match. After a match the rest of the region gives no words.
// Channel cfg_i writes the pattern words, the care mask and the pattern length;
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. One word is accepted in every cycle
// unless a held result stalls the input register. A result passes from the
// input register through the single compare stage into the result register,
// which drives out_o.
// When the receiver stalls, the held result stays on out_o and in_i keeps taking
// words until the input register holds a word that would produce another result.
// Reset clears the region state and sets the registers to an all-zero pattern,
// an all-ones care mask and a length of one byte.
`include "assert_macros.svh"

module masked_byte_pattern_search_top #(
  parameter int unsigned MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
  parameter int unsigned OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  mbps_cfg_if.sink      cfg_i,
  mbps_in_if.sink       in_i,
  mbps_out_if.source    out_o
);
  import mbps_pkg::*;

  localparam int unsigned EFF_MAX   = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
  localparam int unsigned WIN_DEPTH = EFF_MAX - 1;
  localparam int unsigned LEN_W     = $clog2(EFF_MAX + 1);
  localparam int unsigned WIDE_W    = (OFFSET_BITS > OUT_OFF_W) ? OFFSET_BITS : OUT_OFF_W;

  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_q;
  logic [MASK_W-1:0]                    mask_q;
  logic [LEN_CFG_W-1:0]                 len_q;
  cfg_t                                 cfg;

  logic              s1_valid_q;
  logic [DATA_W-1:0] s1_byte_q;
  logic              s1_last_q;

  logic [WIN_DEPTH-1:0][DATA_W-1:0] win_q;
  logic [OFFSET_BITS-1:0]           count_q;
  logic                             reported_q;

  logic                 out_valid_q;
  logic                 found_q;
  logic [OUT_OFF_W-1:0] offset_q;
  logic                 done_q;

  logic [EFF_MAX*DATA_W-1:0] hist;
  logic                      win_hit;
  logic [LEN_W-1:0]          len;
  logic [OFFSET_BITS-1:0]    seen;
  logic [OFFSET_BITS-1:0]    off;
  logic [WIDE_W-1:0]         off_wide;
  logic [OUT_OFF_W-1:0]      offset_d;
  logic                      hit;
  logic                      produce;
  logic                      out_free;
  logic                      s1_adv;
  logic                      in_acc;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      mask_q <= '1;
      len_q  <= LEN_CFG_W'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        REG_PAT_LO:     pat_q[0] <= cfg_i.data;
        REG_PAT_MID_LO: pat_q[1] <= cfg_i.data;
        REG_PAT_MID_HI: pat_q[2] <= cfg_i.data;
        REG_PAT_HI:     pat_q[3] <= cfg_i.data;
        REG_CARE_MASK:  mask_q   <= cfg_i.data[MASK_W-1:0];
        REG_PAT_LEN:    len_q    <= cfg_i.data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern   = pat_q;
  assign cfg.care_mask = mask_q;
  assign cfg.length    = len_q;

  // Compare stage.
  assign hist = {win_q, s1_byte_q};

  mbps_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .cfg_i (cfg),
    .hist_i(hist),
    .hit_o (win_hit),
    .len_o (len)
  );

  always_comb begin
    seen     = (&count_q) ? count_q : count_q + OFFSET_BITS'(1);
    off      = seen - OFFSET_BITS'(len);
    off_wide = WIDE_W'(off);
    if (off_wide > WIDE_W'({OUT_OFF_W{1'b1}})) begin
      offset_d = '1;
    end else begin
      offset_d = off_wide[OUT_OFF_W-1:0];
    end
  end

  assign hit      = win_hit && !reported_q && (seen >= OFFSET_BITS'(len));
  assign produce  = s1_valid_q && (hit || (s1_last_q && !reported_q));
  assign out_free = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && (out_free || !produce);
  assign in_acc   = in_i.valid && in_i.ready;

  assign in_i.ready = !s1_valid_q || s1_adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.region_end;
    end
  end

  // Region state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        count_q    <= '0;
        reported_q <= 1'b0;
      end else begin
        count_q    <= seen;
        reported_q <= reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && !s1_last_q) begin
      for (int k = WIN_DEPTH - 1; k > 0; k--) begin
        win_q[k] <= win_q[k-1];
      end
      win_q[0] <= s1_byte_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce && s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce && s1_adv) begin
      found_q  <= hit;
      offset_q <= hit ? offset_d : '0;
      done_q   <= s1_last_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = offset_q;
  assign out_o.region_done  = done_q;

  `ASSERT_NEVER(a_no_overwrite, produce && s1_adv && out_valid_q && !out_o.ready,
                "result register overwritten while held")
  `ASSERT_CLK(a_report_with_found, $rose(reported_q) |-> out_valid_q && found_q,
              "match flag set without a found word")
  `ASSERT_NEVER(a_report_needs_count, reported_q && (count_q == '0),
                "match flag set at region start")

endmodule
